[sv/alarm_bank_state_manager_assert.svh]
// Assertion macros for the checker of the alarm bank.
// Depends on nothing; take it in with `include by the bare file name.
`ifndef ALARM_BANK_STATE_MANAGER_ASSERT_SVH
`define ALARM_BANK_STATE_MANAGER_ASSERT_SVH

// Property checked on every rising edge, ignored while reset is applied.
`define ABSM_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("alarm bank assertion failed");

// Property checked on every rising edge, reset included.
`define ABSM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("alarm bank assertion failed");

`endif

[sv/abank_pkg.sv]
// Types shared by the alarm bank modules: command and result words, the
// stored entry record and the control group from the update logic. No dependencies.
package abank_pkg;

  typedef enum logic [3:0] {
    CMD_CONFIGURE  = 4'd0,
    CMD_SAMPLE     = 4'd1,
    CMD_ACK        = 4'd2,
    CMD_SHELVE     = 4'd3,
    CMD_UNSHELVE   = 4'd4,
    CMD_SUPPRESS   = 4'd5,
    CMD_UNSUPPRESS = 4'd6,
    CMD_ENABLE     = 4'd7,
    CMD_DISABLE    = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    COND_NORMAL     = 3'd0,
    COND_UNACK      = 3'd1,
    COND_ACK        = 3'd2,
    COND_RTN_UNACK  = 3'd3,
    COND_SHELVED    = 3'd4,
    COND_SUPPRESSED = 3'd5,
    COND_OOS        = 3'd6
  } cond_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_UNCONF  = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [3:0]         alarm_index;
    logic signed [31:0] sample_value;
    logic signed [31:0] new_setpoint;
    logic [30:0]        new_deadband;
    logic [1:0]         new_urgency;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  entry_index;
    logic [2:0]  entry_condition;
    logic [15:0] entry_occurrences;
    logic        became_active;
    logic [15:0] total_active;
    logic [15:0] active_low;
    logic [15:0] active_medium;
    logic [15:0] active_high;
    logic [15:0] active_critical;
  } result_t;

  typedef struct packed {
    cond_e              cond;
    logic [1:0]         urgency;
    logic signed [31:0] setpoint;
    logic [30:0]        deadband;
    logic [15:0]        occurrences;
    logic               enabled;
    logic               suppressed;
    logic               shelved;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  entry_index;
    logic [2:0]  entry_condition;
    logic [15:0] entry_occurrences;
    logic        became_active;
  } item_res_t;

  typedef struct packed {
    logic       wr_en;
    logic       slot_inc;
    logic       cnt_up;
    logic       cnt_dn;
    logic [1:0] urgency;
  } upd_ctrl_t;

endpackage

[sv/abank_entry_mem.sv]
// Entry store of the alarm bank: one synchronous memory of entry records,
// one write port and one read port with registered read data. Uses abank_pkg.
module abank_entry_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  abank_pkg::entry_t   wr_data_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output abank_pkg::entry_t   rd_data_o
);
  import abank_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/abank_update.sv]
// Read-modify-write logic of the alarm bank: from the command word and the
// entry just read it forms the entry to write back and the item result. Uses abank_pkg.
module abank_update #(
  parameter int NUM_ENTRIES = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  abank_pkg::cmd_t     cmd_i,
  input  abank_pkg::entry_t   entry_i,
  input  logic [CW-1:0]       count_i,
  output abank_pkg::upd_ctrl_t ctrl_o,
  output logic [AW-1:0]       wr_addr_o,
  output abank_pkg::entry_t   wr_data_o,
  output abank_pkg::item_res_t res_o
);
  import abank_pkg::*;

  cmd_e               op;
  entry_t             cur;
  entry_t             nxt;
  logic               unconf;
  logic               full;
  logic               live;
  logic               trip;
  logic               clear;
  logic signed [32:0] clr_lvl;
  logic signed [32:0] val_ext;

  assign op  = cmd_e'(cmd_i.cmd);
  assign cur = entry_i;

  assign unconf = (32'(cmd_i.alarm_index) >= 32'(count_i)) ||
                  (32'(cmd_i.alarm_index) >= 32'(NUM_ENTRIES));
  assign full   = 32'(count_i) >= 32'(NUM_ENTRIES);

  // The clear level is taken one bit wider so that it never wraps.
  assign clr_lvl = $signed({cur.setpoint[31], cur.setpoint}) - $signed({2'b00, cur.deadband});
  assign val_ext = $signed({cmd_i.sample_value[31], cmd_i.sample_value});
  assign trip    = cmd_i.sample_value >= cur.setpoint;
  assign clear   = val_ext < clr_lvl;
  assign live    = cur.enabled && !cur.suppressed && !cur.shelved;

  always_comb begin
    nxt           = cur;
    ctrl_o        = '0;
    ctrl_o.urgency = cur.urgency;
    wr_addr_o     = AW'(cmd_i.alarm_index);
    res_o         = '0;

    if (op == CMD_CONFIGURE) begin
      nxt.cond        = COND_NORMAL;
      nxt.urgency     = cmd_i.new_urgency;
      nxt.setpoint    = cmd_i.new_setpoint;
      nxt.deadband    = cmd_i.new_deadband;
      nxt.occurrences = '0;
      nxt.enabled     = 1'b1;
      nxt.suppressed  = 1'b0;
      nxt.shelved     = 1'b0;
      wr_addr_o       = AW'(count_i);
      if (full) begin
        res_o.status = STATUS_FULL;
      end else begin
        ctrl_o.wr_en      = 1'b1;
        ctrl_o.slot_inc   = 1'b1;
        res_o.entry_index = 4'(count_i);
      end
    end else if (unconf) begin
      res_o.status      = STATUS_UNCONF;
      res_o.entry_index = cmd_i.alarm_index;
    end else begin
      ctrl_o.wr_en = 1'b1;
      unique case (op)
        CMD_SAMPLE: begin
          if (live) begin
            if (trip && cur.cond == COND_NORMAL) begin
              nxt.cond = COND_UNACK;
              if (cur.occurrences != 16'hFFFF) begin
                nxt.occurrences = cur.occurrences + 16'd1;
              end
              ctrl_o.cnt_up       = 1'b1;
              res_o.became_active = 1'b1;
            end else if (clear && (cur.cond == COND_ACK || cur.cond == COND_UNACK)) begin
              nxt.cond = COND_RTN_UNACK;
            end
          end
        end
        CMD_ACK: begin
          if (cur.cond == COND_UNACK) begin
            nxt.cond = COND_ACK;
          end else if (cur.cond == COND_RTN_UNACK) begin
            nxt.cond      = COND_NORMAL;
            ctrl_o.cnt_dn = 1'b1;
          end
        end
        CMD_SHELVE: begin
          if (cur.cond != COND_OOS) begin
            nxt.shelved = 1'b1;
            nxt.cond    = COND_SHELVED;
          end
          if (cur.cond == COND_UNACK || cur.cond == COND_ACK ||
              cur.cond == COND_RTN_UNACK) begin
            ctrl_o.cnt_dn = 1'b1;
          end
        end
        CMD_UNSHELVE: begin
          if (cur.cond == COND_SHELVED) begin
            nxt.shelved = 1'b0;
            nxt.cond    = COND_NORMAL;
          end
        end
        CMD_SUPPRESS: begin
          nxt.suppressed = 1'b1;
          if (cur.cond != COND_OOS) begin
            nxt.cond = COND_SUPPRESSED;
          end
        end
        CMD_UNSUPPRESS: begin
          nxt.suppressed = 1'b0;
          if (cur.cond == COND_SUPPRESSED) begin
            nxt.cond = COND_NORMAL;
          end
        end
        CMD_ENABLE: begin
          nxt.enabled = 1'b1;
          if (cur.cond == COND_OOS) begin
            nxt.cond = COND_NORMAL;
          end
        end
        CMD_DISABLE: begin
          nxt.enabled = 1'b0;
          nxt.cond    = COND_OOS;
        end
        default: begin
          // Unknown codes leave the entry as it is and just report it.
        end
      endcase
      res_o.entry_index       = cmd_i.alarm_index;
      res_o.entry_condition   = nxt.cond;
      res_o.entry_occurrences = nxt.occurrences;
    end
  end

  assign wr_data_o = nxt;

endmodule

[sv/alarm_bank_state_manager.sv]
// Top level of the alarm bank state manager: command sequencer, active
// totals and the result register. Uses abank_pkg, abank_entry_mem, abank_update.
//
// Usage. A command word is taken at a rising edge where start is high and
// busy is low. The block then raises busy for one cycle while it reads the
// addressed entry from the entry memory (registered read data), updates
// it and writes it back. The result word appears on result_o together with
// done_o for exactly one cycle, once the busy cycle is over, and is taken
// by the receiver at the end of that cycle; there is no way for the
// receiver to hold it off, so it must capture it then.
// A new command may be issued in the same cycle the previous result is
// shown; a command still in flight holds busy, so no new one is taken.
// This is set by the read-then-write of the entry memory;
// busy keeps two commands from touching the same entry at once.
// Reset clears the number of configured entries, the active totals, the
// sequencer and done_o. The entry memory is not cleared: an entry's
// contents are only used once a configure command has written them.
module alarm_bank_state_manager #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  abank_pkg::cmd_t    cmd_i,
  output logic               done_o,
  output abank_pkg::result_t result_o
);
  import abank_pkg::*;

  localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e        state_q;
  logic          done_q;
  result_t       result_q;
  logic [CW-1:0] count_q;
  logic [15:0]   total_q;
  logic [15:0]   urg_q [4];
  cmd_t          cmd_q;

  logic          accept;
  entry_t        rd_entry;
  entry_t        wr_entry;
  logic [AW-1:0] wr_addr;
  upd_ctrl_t     ctrl;
  item_res_t     item_res;
  logic [15:0]   total_d;
  logic [15:0]   urg_d [4];

  assign busy   = (state_q == S_EXEC);
  assign accept = start && !busy;

  // The command word is held for the execute cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  abank_entry_mem #(
    .DEPTH (NUM_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (busy && ctrl.wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_en_i   (accept),
    .rd_addr_i (AW'(cmd_i.alarm_index)),
    .rd_data_o (rd_entry)
  );

  abank_update #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .AW          (AW),
    .CW          (CW)
  ) u_upd (
    .cmd_i     (cmd_q),
    .entry_i   (rd_entry),
    .count_i   (count_q),
    .ctrl_o    (ctrl),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_entry),
    .res_o     (item_res)
  );

  // Saturating totals. A command raises or clears at most one alarm, so
  // at most one of the two adjustments applies.
  always_comb begin
    total_d = total_q;
    for (int u = 0; u < 4; u++) begin
      urg_d[u] = urg_q[u];
    end
    if (ctrl.cnt_up) begin
      if (total_q != 16'hFFFF) begin
        total_d = total_q + 16'd1;
      end
      if (urg_q[ctrl.urgency] != 16'hFFFF) begin
        urg_d[ctrl.urgency] = urg_q[ctrl.urgency] + 16'd1;
      end
    end else if (ctrl.cnt_dn) begin
      if (total_q != 16'd0) begin
        total_d = total_q - 16'd1;
      end
      if (urg_q[ctrl.urgency] != 16'd0) begin
        urg_d[ctrl.urgency] = urg_q[ctrl.urgency] - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      result_q <= '0;
      count_q  <= '0;
      total_q  <= '0;
      for (int u = 0; u < 4; u++) begin
        urg_q[u] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
          total_q <= total_d;
          for (int u = 0; u < 4; u++) begin
            urg_q[u] <= urg_d[u];
          end
          if (ctrl.slot_inc) begin
            count_q <= count_q + CW'(1);
          end
          result_q.status            <= item_res.status;
          result_q.entry_index       <= item_res.entry_index;
          result_q.entry_condition   <= item_res.entry_condition;
          result_q.entry_occurrences <= item_res.entry_occurrences;
          result_q.became_active     <= item_res.became_active;
          result_q.total_active      <= total_d;
          result_q.active_low        <= urg_d[0];
          result_q.active_medium     <= urg_d[1];
          result_q.active_high       <= urg_d[2];
          result_q.active_critical   <= urg_d[3];
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

[sv/abank_checker.sv]
// Port-level checker for the alarm bank state manager and its bind.
// Uses abank_pkg and the macros of alarm_bank_state_manager_assert.svh.
`include "alarm_bank_state_manager_assert.svh"

module abank_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input abank_pkg::result_t result_o
);
  import abank_pkg::*;

  // A taken command keeps the block busy for exactly one cycle.
  `ABSM_ASSERT_RST(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `ABSM_ASSERT_RST(a_busy_one, clk_i, rst_ni, busy |=> !busy)
  // Every taken command gives its result once its busy cycle is over.
  `ABSM_ASSERT_RST(a_result_lat, clk_i, rst_ni, (start && !busy) |-> ##2 done_o)
  // No result without a command in flight the cycle before.
  `ABSM_ASSERT_RST(a_no_spurious, clk_i, rst_ni, done_o |-> $past(busy))
  // Only a successful command can raise an alarm.
  `ABSM_ASSERT_ALWAYS(a_raise_ok, clk_i,
    (done_o && result_o.status != STATUS_OK) |-> !result_o.became_active)

endmodule

bind alarm_bank_state_manager abank_checker u_abank_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
